// ===== sv/tpfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfs_pkg
// Shared types and constants for the two-pool page free stack.
// ----------------------------------------------------------------------------
package tpfs_pkg;

    localparam int ADDR_W   = 56;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC_SMALL = 2'd0,
        CMD_FREE_SMALL  = 2'd1,
        CMD_ALLOC_SUPER = 2'd2,
        CMD_FREE_SUPER  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    localparam logic [CFG_IDX_W-1:0] REG_MEM_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_TOP   = 2'd1;

    localparam logic [ADDR_W-1:0] MEM_START_RESET = 56'h0000_0080_000_000;
    localparam logic [ADDR_W-1:0] MEM_TOP_RESET   = 56'h0000_0088_000_000;

endpackage

// ===== sv/tpfs_if.sv =====
// ----------------------------------------------------------------------------
// tpfs_if
// Valid/ready channels of the page free stack: command, result and
// configuration write.
// ----------------------------------------------------------------------------
interface tpfs_cmd_if import tpfs_pkg::*; ();
    logic                valid;
    logic                ready;
    t_cmd                cmd;
    logic [ADDR_W-1:0]   addr;

    modport source (output valid, output cmd, output addr, input ready);
    modport sink   (input valid, input cmd, input addr, output ready);
endinterface

interface tpfs_res_if import tpfs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   page_addr;
    t_status             status;

    modport source (output valid, output page_addr, output status, input ready);
    modport sink   (input valid, input page_addr, input status, output ready);
endinterface

interface tpfs_cfg_if import tpfs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/two_pool_page_free_stack.sv =====
// ----------------------------------------------------------------------------
// two_pool_page_free_stack
// Page allocator with two lifo free pools, small pages and superpages.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one request: cmd (alloc/free, small/super) and addr.
//   o_res returns exactly one result per request: page_addr and status
//   (ok, empty, bad address, full). i_cfg writes mem_start (index 0) and
//   mem_top (index 1); other indexes are dropped. i_cfg is always ready.
// Result timing:
//   a free or an allocate from an empty pool shows its result in the cycle
//   after acceptance, and the next request can enter in that cycle if the
//   receiver takes the result (one per cycle). A successful allocate reads
//   its stack memory into a registered read port in the READ state, then
//   moves the page to the output register; no new request is taken in READ.
// Reset:
//   both pools become empty, the range registers take their reset values;
//   stack memories are not cleared, only entries below the count are read.
// Stall:
//   the result sits in an output register; a new request is taken while it
//   waits only in the cycle that the receiver takes it.
// ----------------------------------------------------------------------------
module two_pool_page_free_stack import tpfs_pkg::*; #(
    parameter int SMALL_DEPTH     = 32768,
    parameter int SUPER_DEPTH     = 64,
    parameter int SMALL_PAGE_BITS = 12,
    parameter int SUPER_PAGE_BITS = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpfs_cmd_if.sink    i_cmd,
    tpfs_cfg_if.sink    i_cfg,
    tpfs_res_if.source  o_res
);

    localparam int SMALL_W  = ADDR_W - SMALL_PAGE_BITS;
    localparam int SUPER_W  = ADDR_W - SUPER_PAGE_BITS;
    localparam int SMALL_CW = $clog2(SMALL_DEPTH + 1);
    localparam int SUPER_CW = $clog2(SUPER_DEPTH + 1);
    localparam int SMALL_IW = (SMALL_DEPTH > 1) ? $clog2(SMALL_DEPTH) : 1;
    localparam int SUPER_IW = (SUPER_DEPTH > 1) ? $clog2(SUPER_DEPTH) : 1;

    logic [SMALL_W-1:0] small_mem [SMALL_DEPTH];
    logic [SUPER_W-1:0] super_mem [SUPER_DEPTH];

    t_state              r_state, n_state;
    logic [SMALL_CW-1:0] r_small_cnt, n_small_cnt;
    logic [SUPER_CW-1:0] r_super_cnt, n_super_cnt;
    logic                r_pop_super, n_pop_super;
    logic                r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]   r_out_page, n_out_page;
    t_status             r_out_status, n_out_status;
    logic [ADDR_W-1:0]   r_mem_start, r_mem_top;
    logic [SMALL_W-1:0]  r_small_rd;
    logic [SUPER_W-1:0]  r_super_rd;

    logic                cmd_acc;
    logic                in_range;
    logic                small_ok, super_ok;
    logic                small_wr, super_wr, small_rd, super_rd;
    logic [SMALL_IW-1:0] small_wr_idx, small_rd_idx;
    logic [SUPER_IW-1:0] super_wr_idx, super_rd_idx;

    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid     = r_out_valid;
    assign o_res.page_addr = r_out_page;
    assign o_res.status    = r_out_status;

    assign in_range = (i_cmd.addr >= r_mem_start) && (i_cmd.addr < r_mem_top);
    assign small_ok = in_range && (i_cmd.addr[SMALL_PAGE_BITS-1:0] == '0);
    assign super_ok = in_range && (i_cmd.addr[SUPER_PAGE_BITS-1:0] == '0);

    assign small_wr_idx = SMALL_IW'(r_small_cnt);
    assign super_wr_idx = SUPER_IW'(r_super_cnt);
    assign small_rd_idx = SMALL_IW'(r_small_cnt - SMALL_CW'(1));
    assign super_rd_idx = SUPER_IW'(r_super_cnt - SUPER_CW'(1));

    always_comb begin
        n_state      = r_state;
        n_small_cnt  = r_small_cnt;
        n_super_cnt  = r_super_cnt;
        n_pop_super  = r_pop_super;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_page   = r_out_page;
        n_out_status = r_out_status;
        small_wr     = 1'b0;
        super_wr     = 1'b0;
        small_rd     = 1'b0;
        super_rd     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    n_out_page = '0;
                    case (i_cmd.cmd)
                        CMD_ALLOC_SMALL: begin
                            if (r_small_cnt == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                            end else begin
                                small_rd    = 1'b1;
                                n_small_cnt = r_small_cnt - SMALL_CW'(1);
                                n_pop_super = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        CMD_FREE_SMALL: begin
                            n_out_valid = 1'b1;
                            if (!small_ok) begin
                                n_out_status = ST_BAD;
                            end else if (r_small_cnt == SMALL_CW'(SMALL_DEPTH)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                small_wr     = 1'b1;
                                n_small_cnt  = r_small_cnt + SMALL_CW'(1);
                                n_out_status = ST_OK;
                            end
                        end
                        CMD_ALLOC_SUPER: begin
                            if (r_super_cnt == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                            end else begin
                                super_rd    = 1'b1;
                                n_super_cnt = r_super_cnt - SUPER_CW'(1);
                                n_pop_super = 1'b1;
                                n_state     = S_READ;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            if (!super_ok) begin
                                n_out_status = ST_BAD;
                            end else if (r_super_cnt == SUPER_CW'(SUPER_DEPTH)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                super_wr     = 1'b1;
                                n_super_cnt  = r_super_cnt + SUPER_CW'(1);
                                n_out_status = ST_OK;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                // registered read data of the popped entry is ready now
                n_out_valid  = 1'b1;
                n_out_status = ST_OK;
                if (r_pop_super) begin
                    n_out_page = {r_super_rd, {SUPER_PAGE_BITS{1'b0}}};
                end else begin
                    n_out_page = {r_small_rd, {SMALL_PAGE_BITS{1'b0}}};
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_small_cnt <= '0;
            r_super_cnt <= '0;
            r_pop_super <= 1'b0;
            r_out_valid <= 1'b0;
            r_mem_start <= MEM_START_RESET;
            r_mem_top   <= MEM_TOP_RESET;
        end else begin
            r_state     <= n_state;
            r_small_cnt <= n_small_cnt;
            r_super_cnt <= n_super_cnt;
            r_pop_super <= n_pop_super;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_MEM_START: r_mem_start <= i_cfg.data;
                    REG_MEM_TOP:   r_mem_top   <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_page   <= n_out_page;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (small_wr) begin
            small_mem[small_wr_idx] <= i_cmd.addr[ADDR_W-1:SMALL_PAGE_BITS];
        end
        if (small_rd) begin
            r_small_rd <= small_mem[small_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (super_wr) begin
            super_mem[super_wr_idx] <= i_cmd.addr[ADDR_W-1:SUPER_PAGE_BITS];
        end
        if (super_rd) begin
            r_super_rd <= super_mem[super_rd_idx];
        end
    end

    // pool counts never pass their depth
    a_small_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_small_cnt <= SMALL_CW'(SMALL_DEPTH))
        else $error("small pool count above depth");

    a_super_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_super_cnt <= SUPER_CW'(SUPER_DEPTH))
        else $error("super pool count above depth");

    // the output register is free while a pop waits on its read data
    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("pending result while pop read in flight");

    // every free request gets its result in the next cycle
    a_free_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && (i_cmd.cmd == CMD_FREE_SMALL || i_cmd.cmd == CMD_FREE_SUPER))
        |=> r_out_valid)
        else $error("free request without result");

    // a pop always ends with an ok result
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_out_valid && r_out_status == ST_OK))
        else $error("pop did not deliver a page");

endmodule
